// File: sv/vsa_pkg.sv
package vsa_pkg;

   // request codes
   localparam logic [3:0] ACT_TICK       = 4'd0;
   localparam logic [3:0] ACT_CTRL_WR    = 4'd1;
   localparam logic [3:0] ACT_MASK_WR    = 4'd2;
   localparam logic [3:0] ACT_SCROLL_WR  = 4'd3;
   localparam logic [3:0] ACT_ADDR_WR    = 4'd4;
   localparam logic [3:0] ACT_DATA_WR    = 4'd5;
   localparam logic [3:0] ACT_DATA_RD    = 4'd6;
   localparam logic [3:0] ACT_STATUS_RD  = 4'd7;
   localparam logic [3:0] ACT_INC_X      = 4'd8;
   localparam logic [3:0] ACT_INC_Y      = 4'd9;
   localparam logic [3:0] ACT_COPY_HORIZ = 4'd10;
   localparam logic [3:0] ACT_COPY_VERT  = 4'd11;

   // address field masks
   localparam logic [15:0] NT_SELECT_KEEP = 16'hF3FF;
   localparam logic [15:0] SCROLL_Y_KEEP  = 16'h8C1F;
   localparam logic [15:0] ADDR_MASK      = 16'h7FFF;
   localparam logic [15:0] COARSE_Y_MASK  = 16'h03E0;
   localparam logic [15:0] COARSE_X_CLEAR = 16'hFFE0;
   localparam logic [15:0] NT_X_FLIP      = 16'h0400;
   localparam logic [15:0] NT_Y_FLIP      = 16'h0800;
   localparam logic [15:0] HORIZ_KEEP     = 16'hFBE0;
   localparam logic [15:0] HORIZ_COPY     = 16'h041F;
   localparam logic [15:0] VERT_KEEP      = 16'h841F;
   localparam logic [15:0] VERT_COPY      = 16'h7BE0;
   localparam logic [15:0] FINE_Y_MASK    = 16'h7000;
   localparam logic [15:0] FINE_Y_CLEAR   = 16'h8FFF;
   localparam logic [15:0] FINE_Y_ONE     = 16'h1000;
   localparam logic [15:0] COARSE_Y_CLEAR = 16'hFC1F;
   localparam logic [15:0] LOW_BYTE_KEEP  = 16'h00FF;
   localparam logic [15:0] HIGH_BYTE_KEEP = 16'hFF00;
   localparam logic [4:0]  COARSE_Y_WRAP  = 5'h1D;
   localparam logic [4:0]  COARSE_Y_LAST  = 5'h1F;
   localparam logic [13:0] TILE_BASE      = 14'h2000;
   localparam logic [13:0] ATTR_BASE      = 14'h23C0;

   localparam logic [1:0] COPY_DELAY_START = 2'd3;
   localparam logic [2:0] LOCKOUT_START    = 3'd6;

   typedef struct packed {
      logic [3:0] action;
      logic [7:0] value;
      logic       active_lines;
   } req_type;

   typedef struct packed {
      logic [15:0] access_address;
      logic        access_valid;
      logic [15:0] vram_address;
      logic [15:0] temp_address;
      logic [2:0]  fine_scroll_x;
      logic        write_toggle;
      logic [13:0] tile_fetch_address;
      logic [13:0] attribute_fetch_address;
   } rsp_type;

   typedef struct packed {
      logic [15:0] current_addr;
      logic [15:0] temp_addr;
      logic [15:0] pending_addr;
      logic [2:0]  fine_x;
      logic        toggle;
      logic        step_by_row;
      logic        render_on;
      logic [1:0]  copy_delay;
      logic [2:0]  read_lockout;
      logic        mask_show;
   } state_type;

endpackage

// File: sv/vsa_req_if.sv
interface vsa_req_if;
   logic       valid;
   logic       ready;
   logic [3:0] action;
   logic [7:0] value;
   logic       active_lines;

   modport source (output valid, action, value, active_lines, input ready);
   modport sink (input valid, action, value, active_lines, output ready);
endinterface

// File: sv/vsa_rsp_if.sv
interface vsa_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] access_address;
   logic        access_valid;
   logic [15:0] vram_address;
   logic [15:0] temp_address;
   logic [2:0]  fine_scroll_x;
   logic        write_toggle;
   logic [13:0] tile_fetch_address;
   logic [13:0] attribute_fetch_address;

   modport source (output valid, access_address, access_valid, vram_address, temp_address,
                   fine_scroll_x, write_toggle, tile_fetch_address,
                   attribute_fetch_address, input ready);
   modport sink (input valid, access_address, access_valid, vram_address, temp_address,
                 fine_scroll_x, write_toggle, tile_fetch_address,
                 attribute_fetch_address, output ready);
endinterface

// File: sv/vram_scroll_address_unit.sv
// Scroll and video address register unit.
// req_ch carries one request per handshake: an action code (tick, register
// write or read, or a rendering event such as coarse X / Y increment or a
// horizontal / vertical copy), the byte written and the active-line flag.
// rsp_ch returns exactly one response per request, in order: the data access
// address and valid flag, the current and temporary addresses after the
// request, fine X, the write toggle and the tile and attribute fetch addresses.
// A request is taken into an input register; when the response register is
// free, the update logic reads the held address state, writes the new state
// and loads the response register, from which the response is offered. One
// request per cycle is sustained while the receiver takes responses; the
// address state loop runs through the update logic and one state register.
// If the receiver stalls, the response register holds and one more request
// is still taken into the input register; req_ch.ready drops only when both
// are full. Synchronous reset clears all address state, counters and flags
// and empties both registers.
module vram_scroll_address_unit (
   input logic       clock,
   input logic       reset,
   vsa_req_if.sink   req_ch,
   vsa_rsp_if.source rsp_ch
);

   logic               in_valid_ff;
   logic               in_valid_in;
   vsa_pkg::req_type   in_data_ff;
   logic               out_valid_ff;
   logic               out_valid_in;
   vsa_pkg::rsp_type   out_data_ff;
   vsa_pkg::state_type state_ff;
   vsa_pkg::state_type state_in;
   vsa_pkg::rsp_type   step_rsp;
   logic               out_free;
   logic               step_fire;
   logic               req_take;

   assign out_free  = !out_valid_ff || rsp_ch.ready;
   assign step_fire = in_valid_ff && out_free;
   assign req_take  = req_ch.valid && req_ch.ready;

   assign req_ch.ready = !in_valid_ff || out_free;

   vsa_step u_step (
      .state_i (state_ff),
      .req_i   (in_data_ff),
      .state_o (state_in),
      .rsp_o   (step_rsp)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ch.ready) begin
         in_valid_in = req_ch.valid;
      end
      out_valid_in = out_valid_ff;
      if (out_free) begin
         out_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (step_fire) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff.action       <= req_ch.action;
         in_data_ff.value        <= req_ch.value;
         in_data_ff.active_lines <= req_ch.active_lines;
      end
      if (step_fire) begin
         out_data_ff <= step_rsp;
      end
   end

   assign rsp_ch.valid                   = out_valid_ff;
   assign rsp_ch.access_address          = out_data_ff.access_address;
   assign rsp_ch.access_valid            = out_data_ff.access_valid;
   assign rsp_ch.vram_address            = out_data_ff.vram_address;
   assign rsp_ch.temp_address            = out_data_ff.temp_address;
   assign rsp_ch.fine_scroll_x           = out_data_ff.fine_scroll_x;
   assign rsp_ch.write_toggle            = out_data_ff.write_toggle;
   assign rsp_ch.tile_fetch_address      = out_data_ff.tile_fetch_address;
   assign rsp_ch.attribute_fetch_address = out_data_ff.attribute_fetch_address;

   // address state moves only when a request goes through the update logic
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !step_fire |=> $stable(state_ff))
      else $error("address state changed without a request");

   // an unlocked data read arms the full lockout
   a_lockout_arm: assert property (@(posedge clock) disable iff (reset)
      step_fire && in_data_ff.action == vsa_pkg::ACT_DATA_RD
      && state_ff.read_lockout == 3'd0 |=> state_ff.read_lockout == vsa_pkg::LOCKOUT_START)
      else $error("data read did not arm lockout");

   // only data reads and writes report a VRAM access
   a_access_kind: assert property (@(posedge clock) disable iff (reset)
      step_fire && step_rsp.access_valid |->
      in_data_ff.action == vsa_pkg::ACT_DATA_WR || in_data_ff.action == vsa_pkg::ACT_DATA_RD)
      else $error("access reported for a non-data request");

   a_lockout_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.read_lockout <= vsa_pkg::LOCKOUT_START)
      else $error("read lockout out of range");

endmodule

// File: sv/vsa_step.sv
module vsa_step (
   input  vsa_pkg::state_type state_i,
   input  vsa_pkg::req_type   req_i,
   output vsa_pkg::state_type state_o,
   output vsa_pkg::rsp_type   rsp_o
);

   function automatic logic [15:0] coarse_x_step(input logic [15:0] addr, input logic show);
      logic [15:0] res;
      res = addr;
      if (show) begin
         if (addr[4:0] == 5'h1F) begin
            res = (addr & vsa_pkg::COARSE_X_CLEAR) ^ vsa_pkg::NT_X_FLIP;
         end else begin
            res = addr + 16'd1;
         end
      end
      return res;
   endfunction

   function automatic logic [15:0] y_step(input logic [15:0] addr, input logic show);
      logic [15:0] res;
      logic [4:0]  cy;
      res = addr;
      cy  = addr[9:5];
      if (show) begin
         if ((addr & vsa_pkg::FINE_Y_MASK) != vsa_pkg::FINE_Y_MASK) begin
            res = addr + vsa_pkg::FINE_Y_ONE;
         end else begin
            res = addr & vsa_pkg::FINE_Y_CLEAR;
            // row 29 is the last tile row: wrap and switch vertical nametable
            if (cy == vsa_pkg::COARSE_Y_WRAP) begin
               cy  = 5'd0;
               res = res ^ vsa_pkg::NT_Y_FLIP;
            end else if (cy == vsa_pkg::COARSE_Y_LAST) begin
               cy = 5'd0;
            end else begin
               cy = cy + 5'd1;
            end
            res = (res & vsa_pkg::COARSE_Y_CLEAR) | ({11'd0, cy} << 5);
         end
      end
      return res;
   endfunction

   always_comb begin
      vsa_pkg::state_type nxt;
      logic [15:0]        acc_addr;
      logic               acc_valid;
      logic               do_access;
      logic [15:0]        low_written;

      nxt         = state_i;
      acc_addr    = 16'd0;
      acc_valid   = 1'b0;
      do_access   = 1'b0;
      low_written = {state_i.temp_addr[15:8], req_i.value};

      unique case (req_i.action)
         vsa_pkg::ACT_TICK: begin
            nxt.render_on = state_i.mask_show;
            if (state_i.copy_delay != 2'd0) begin
               nxt.copy_delay = state_i.copy_delay - 2'd1;
               if (state_i.copy_delay == 2'd1) begin
                  nxt.current_addr = state_i.pending_addr;
                  nxt.temp_addr    = state_i.pending_addr;
               end
            end
            if (state_i.read_lockout != 3'd0) begin
               nxt.read_lockout = state_i.read_lockout - 3'd1;
            end
         end
         vsa_pkg::ACT_CTRL_WR: begin
            nxt.temp_addr = (state_i.temp_addr & vsa_pkg::NT_SELECT_KEEP)
                            | ({14'd0, req_i.value[1:0]} << 10);
            nxt.step_by_row = req_i.value[2];
         end
         vsa_pkg::ACT_MASK_WR: begin
            nxt.mask_show = req_i.value[3] | req_i.value[4];
         end
         vsa_pkg::ACT_SCROLL_WR: begin
            if (!state_i.toggle) begin
               nxt.fine_x    = req_i.value[2:0];
               nxt.temp_addr = (state_i.temp_addr & vsa_pkg::COARSE_X_CLEAR)
                               | {11'd0, req_i.value[7:3]};
            end else begin
               nxt.temp_addr = (state_i.temp_addr & vsa_pkg::SCROLL_Y_KEEP)
                               | ({11'd0, req_i.value[7:3]} << 5)
                               | ({13'd0, req_i.value[2:0]} << 12);
            end
            nxt.toggle = ~state_i.toggle;
         end
         vsa_pkg::ACT_ADDR_WR: begin
            if (!state_i.toggle) begin
               // high byte: bit 14 and up are cleared
               nxt.temp_addr = (state_i.temp_addr & vsa_pkg::LOW_BYTE_KEEP)
                               | ({10'd0, req_i.value[5:0]} << 8);
            end else begin
               nxt.temp_addr    = (state_i.temp_addr & vsa_pkg::HIGH_BYTE_KEEP)
                                  | {8'd0, req_i.value};
               nxt.pending_addr = low_written;
               nxt.copy_delay   = vsa_pkg::COPY_DELAY_START;
            end
            nxt.toggle = ~state_i.toggle;
         end
         vsa_pkg::ACT_DATA_WR: begin
            do_access = 1'b1;
         end
         vsa_pkg::ACT_DATA_RD: begin
            if (state_i.read_lockout == 3'd0) begin
               do_access        = 1'b1;
               nxt.read_lockout = vsa_pkg::LOCKOUT_START;
            end
         end
         vsa_pkg::ACT_STATUS_RD: begin
            nxt.toggle = 1'b0;
         end
         vsa_pkg::ACT_INC_X: begin
            nxt.current_addr = coarse_x_step(state_i.current_addr, state_i.mask_show);
         end
         vsa_pkg::ACT_INC_Y: begin
            nxt.current_addr = y_step(state_i.current_addr, state_i.mask_show);
         end
         vsa_pkg::ACT_COPY_HORIZ: begin
            if (state_i.mask_show) begin
               nxt.current_addr = (state_i.current_addr & vsa_pkg::HORIZ_KEEP)
                                  | (state_i.temp_addr & vsa_pkg::HORIZ_COPY);
            end
         end
         vsa_pkg::ACT_COPY_VERT: begin
            if (state_i.mask_show) begin
               nxt.current_addr = (state_i.current_addr & vsa_pkg::VERT_KEEP)
                                  | (state_i.temp_addr & vsa_pkg::VERT_COPY);
            end
         end
         default: begin
         end
      endcase

      if (do_access) begin
         acc_addr  = state_i.current_addr;
         acc_valid = 1'b1;
         // outside rendering the address steps by 1 or 32; during rendering it
         // takes the coarse x and the y increments instead
         if (!req_i.active_lines || !state_i.render_on) begin
            nxt.current_addr = (state_i.current_addr
                                + (state_i.step_by_row ? 16'd32 : 16'd1))
                               & vsa_pkg::ADDR_MASK;
         end else begin
            nxt.current_addr = y_step(coarse_x_step(state_i.current_addr,
                                                    state_i.mask_show),
                                      state_i.mask_show);
         end
      end

      state_o = nxt;

      rsp_o.access_address = acc_addr;
      rsp_o.access_valid   = acc_valid;
      rsp_o.vram_address   = nxt.current_addr;
      rsp_o.temp_address   = nxt.temp_addr;
      rsp_o.fine_scroll_x  = nxt.fine_x;
      rsp_o.write_toggle   = nxt.toggle;
      rsp_o.tile_fetch_address = vsa_pkg::TILE_BASE | {2'b00, nxt.current_addr[11:0]};
      rsp_o.attribute_fetch_address = vsa_pkg::ATTR_BASE
                                      | {2'b00, nxt.current_addr[11:10], 10'd0}
                                      | {8'd0, nxt.current_addr[9:7], 3'd0}
                                      | {11'd0, nxt.current_addr[4:2]};
   end

endmodule

// File: bench/tb_vram_scroll_address_unit.sv
`timescale 1ns / 1ps

module tb_vram_scroll_address_unit;
   import vsa_pkg::*;

   localparam logic [3:0] ACT_RESERVED_LO = 4'd12;
   localparam logic [3:0] ACT_RESERVED_HI = 4'd15;
   localparam int RANDOM_ITEMS = 800;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 20;

   class scroll_address_tracker;
      logic [15:0] cur;
      logic [15:0] tmp;
      logic [15:0] pend;
      logic [2:0]  fine_x;
      logic        toggle;
      logic        by_row;
      logic        render_on;
      logic        mask_show;
      logic [1:0]  copy_delay;
      logic [2:0]  lockout;
      rsp_type     expected_snapshots[$];
      int errors;
      int responses;
      int accesses;
      int locked_reads;
      int delayed_loads;
      int y_flips;

      function new();
         cur = '0;
         tmp = '0;
         pend = '0;
         fine_x = '0;
         toggle = 1'b0;
         by_row = 1'b0;
         render_on = 1'b0;
         mask_show = 1'b0;
         copy_delay = '0;
         lockout = '0;
         errors = 0;
         responses = 0;
         accesses = 0;
         locked_reads = 0;
         delayed_loads = 0;
         y_flips = 0;
      endfunction

      function int outstanding();
         return expected_snapshots.size();
      endfunction

      function void step_coarse_x();
         if (!mask_show) return;
         if (cur[4:0] == 5'h1F) cur = (cur & COARSE_X_CLEAR) ^ NT_X_FLIP;
         else cur = cur + 16'd1;
      endfunction

      function void step_y();
         logic [4:0] cy;
         if (!mask_show) return;
         if ((cur & FINE_Y_MASK) != FINE_Y_MASK) begin
            cur = cur + FINE_Y_ONE;
            return;
         end
         cur = cur & FINE_Y_CLEAR;
         cy = cur[9:5];
         if (cy == COARSE_Y_WRAP) begin
            cy = '0;
            cur = cur ^ NT_Y_FLIP;
            y_flips++;
         end else if (cy == COARSE_Y_LAST) begin
            cy = '0;
         end else begin
            cy = cy + 5'd1;
         end
         cur = (cur & COARSE_Y_CLEAR) | {6'b0, cy, 5'b0};
      endfunction

      function void vram_access(input logic act_lines, ref rsp_type snap);
         snap.access_address = cur;
         snap.access_valid = 1'b1;
         accesses++;
         if (!act_lines || !render_on) begin
            cur = (cur + (by_row ? 16'd32 : 16'd1)) & ADDR_MASK;
         end else begin
            step_coarse_x();
            step_y();
         end
      endfunction

      function void note_request(input req_type r);
         rsp_type snap;
         logic [7:0] v;
         v = r.value;
         snap = '0;
         case (r.action)
            ACT_TICK: begin
               render_on = mask_show;
               if (copy_delay != 0) begin
                  copy_delay = copy_delay - 2'd1;
                  if (copy_delay == 0) begin
                     cur = pend;
                     tmp = pend;
                     delayed_loads++;
                  end
               end
               if (lockout != 0) lockout = lockout - 3'd1;
            end
            ACT_CTRL_WR: begin
               tmp = (tmp & NT_SELECT_KEEP) | {4'b0, v[1:0], 10'b0};
               by_row = v[2];
            end
            ACT_MASK_WR: mask_show = v[3] | v[4];
            ACT_SCROLL_WR: begin
               if (!toggle) begin
                  fine_x = v[2:0];
                  tmp = (tmp & COARSE_X_CLEAR) | {11'b0, v[7:3]};
               end else begin
                  tmp = (tmp & SCROLL_Y_KEEP) | {6'b0, v[7:3], 5'b0} | {1'b0, v[2:0], 12'b0};
               end
               toggle = ~toggle;
            end
            ACT_ADDR_WR: begin
               if (!toggle) begin
                  tmp = (tmp & LOW_BYTE_KEEP) | {2'b0, v[5:0], 8'b0};
               end else begin
                  tmp = (tmp & HIGH_BYTE_KEEP) | {8'b0, v};
                  pend = tmp;
                  copy_delay = COPY_DELAY_START;
               end
               toggle = ~toggle;
            end
            ACT_DATA_WR: vram_access(r.active_lines, snap);
            ACT_DATA_RD: begin
               if (lockout == 0) begin
                  vram_access(r.active_lines, snap);
                  lockout = LOCKOUT_START;
               end else begin
                  locked_reads++;
               end
            end
            ACT_STATUS_RD: toggle = 1'b0;
            ACT_INC_X: step_coarse_x();
            ACT_INC_Y: step_y();
            ACT_COPY_HORIZ: if (mask_show) cur = (cur & HORIZ_KEEP) | (tmp & HORIZ_COPY);
            ACT_COPY_VERT: if (mask_show) cur = (cur & VERT_KEEP) | (tmp & VERT_COPY);
            default: ;
         endcase
         snap.vram_address = cur;
         snap.temp_address = tmp;
         snap.fine_scroll_x = fine_x;
         snap.write_toggle = toggle;
         snap.tile_fetch_address = TILE_BASE | {2'b0, cur[11:0]};
         snap.attribute_fetch_address = ATTR_BASE | {2'b0, cur[11:10], 10'b0}
                                        | {8'b0, cur[9:7], 3'b0} | {11'b0, cur[4:2]};
         expected_snapshots.push_back(snap);
      endfunction

      task report(input string what, input logic [15:0] got, input logic [15:0] want);
         errors++;
         $display("mismatch at response %0d: %s got %h expected %h",
                  responses, what, got, want);
      endtask

      task compare_field(input string what, input logic [15:0] got, input logic [15:0] want);
         if (got !== want) report(what, got, want);
      endtask

      task check_response(input rsp_type got);
         rsp_type want;
         responses++;
         if (expected_snapshots.size() == 0) begin
            report("response with no request outstanding", got.vram_address, '0);
            return;
         end
         want = expected_snapshots.pop_front();
         compare_field("access_address", got.access_address, want.access_address);
         compare_field("access_valid", 16'(got.access_valid), 16'(want.access_valid));
         compare_field("vram_address", got.vram_address, want.vram_address);
         compare_field("temp_address", got.temp_address, want.temp_address);
         compare_field("fine_scroll_x", 16'(got.fine_scroll_x), 16'(want.fine_scroll_x));
         compare_field("write_toggle", 16'(got.write_toggle), 16'(want.write_toggle));
         compare_field("tile_fetch_address", 16'(got.tile_fetch_address),
                       16'(want.tile_fetch_address));
         compare_field("attribute_fetch_address", 16'(got.attribute_fetch_address),
                       16'(want.attribute_fetch_address));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   int cycle_count = 0;
   int items_sent = 0;
   bit sender_idles = 1'b1;
   bit receiver_stalls = 1'b1;
   scroll_address_tracker book;

   vsa_req_if req_if ();
   vsa_rsp_if rsp_if ();

   vram_scroll_address_unit DUT (
      .clock(clock),
      .reset(reset),
      .req_ch(req_if),
      .rsp_ch(rsp_if)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TB_ERROR");
      $finish;
   end

   function automatic logic on_active_line();
      return $urandom_range(0, 7) != 0;
   endfunction

   // valid stays high between back-to-back requests
   task automatic send_request(input logic [3:0] act, input logic [7:0] val,
                               input logic act_lines);
      int gap;
      req_type r;
      gap = sender_idles ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.action <= act;
      req_if.value <= val;
      req_if.active_lines <= act_lines;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      r.action = act;
      r.value = val;
      r.active_lines = act_lines;
      book.note_request(r);
      if (act < ACT_RESERVED_LO) items_sent++;
   endtask

   task automatic pause_requests();
      req_if.valid <= 1'b0;
      while (book.outstanding() != 0) @(posedge clock);
   endtask

   task automatic send_ticks(input int n);
      repeat (n) send_request(ACT_TICK, 8'($urandom), on_active_line());
   endtask

   task automatic send_mask_write();
      logic [7:0] v;
      v = 8'($urandom);
      if ($urandom_range(0, 3) != 0) v = v | ($urandom_range(0, 1) ? 8'h08 : 8'h10);
      send_request(ACT_MASK_WR, v, on_active_line());
   endtask

   initial begin
      rsp_type got;
      int stall;
      rsp_if.ready = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         stall = receiver_stalls ? $urandom_range(0, 9) : 0;
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (rsp_if.valid !== 1'b1);
         got.access_address = rsp_if.access_address;
         got.access_valid = rsp_if.access_valid;
         got.vram_address = rsp_if.vram_address;
         got.temp_address = rsp_if.temp_address;
         got.fine_scroll_x = rsp_if.fine_scroll_x;
         got.write_toggle = rsp_if.write_toggle;
         got.tile_fetch_address = rsp_if.tile_fetch_address;
         got.attribute_fetch_address = rsp_if.attribute_fetch_address;
         book.check_response(got);
      end
   end

   initial begin
      int kind;
      int base;
      int next_pause;
      int next_mode;
      req_if.valid = 1'b0;
      req_if.action = ACT_TICK;
      req_if.value = '0;
      req_if.active_lines = 1'b0;
      book = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: quiet accesses, lockout, delayed copy, wraps, gating
      send_request(ACT_TICK, 8'h00, 1'b0);
      send_request(ACT_DATA_WR, 8'h00, 1'b1);
      send_request(ACT_CTRL_WR, 8'hFF, 1'b0);
      send_request(ACT_DATA_RD, 8'h00, 1'b0);
      send_request(ACT_DATA_RD, 8'h00, 1'b0);
      send_request(ACT_STATUS_RD, 8'h00, 1'b0);
      send_request(ACT_ADDR_WR, 8'hFF, 1'b0);
      send_request(ACT_ADDR_WR, 8'hFF, 1'b0);
      send_ticks(3);
      send_request(ACT_MASK_WR, 8'h18, 1'b1);
      send_request(ACT_INC_X, 8'h00, 1'b1);
      send_request(ACT_SCROLL_WR, 8'hFF, 1'b1);
      send_request(ACT_SCROLL_WR, 8'hFF, 1'b1);
      send_request(ACT_COPY_VERT, 8'h00, 1'b1);
      send_request(ACT_INC_Y, 8'h00, 1'b1);
      send_request(ACT_COPY_HORIZ, 8'h00, 1'b1);
      send_request(ACT_SCROLL_WR, 8'h00, 1'b1);
      send_request(ACT_SCROLL_WR, 8'hEF, 1'b1);
      send_request(ACT_COPY_VERT, 8'h00, 1'b1);
      send_request(ACT_INC_Y, 8'h00, 1'b1);
      send_request(ACT_TICK, 8'h00, 1'b1);
      send_request(ACT_DATA_WR, 8'h00, 1'b1);
      send_request(ACT_MASK_WR, 8'h00, 1'b1);
      send_request(ACT_INC_X, 8'h00, 1'b1);
      send_request(ACT_RESERVED_LO, 8'hAA, 1'b1);
      send_request(ACT_RESERVED_HI, 8'h55, 1'b0);
      pause_requests();

      base = items_sent;
      next_pause = 200;
      next_mode = 60;
      while (items_sent - base < RANDOM_ITEMS) begin
         if (items_sent - base >= next_mode) begin
            sender_idles = $urandom_range(0, 3) != 0;
            receiver_stalls = $urandom_range(0, 3) != 0;
            next_mode += $urandom_range(30, 90);
         end
         if (items_sent - base >= next_pause) begin
            pause_requests();
            next_pause += 200;
         end
         kind = $urandom_range(0, 99);
         if (kind < 15) begin
            send_request(ACT_ADDR_WR, 8'($urandom), on_active_line());
            send_request(ACT_ADDR_WR, 8'($urandom), on_active_line());
            send_ticks($urandom_range(0, 4));
         end else if (kind < 25) begin
            send_request(ACT_SCROLL_WR, 8'($urandom), on_active_line());
            send_request(ACT_SCROLL_WR, 8'($urandom), on_active_line());
         end else if (kind < 50) begin
            // one stretch of a scanline
            if ($urandom_range(0, 3) == 0) send_mask_write();
            send_request(ACT_TICK, 8'($urandom), on_active_line());
            repeat ($urandom_range(1, 8)) send_request(ACT_INC_X, 8'($urandom), on_active_line());
            send_request(ACT_INC_Y, 8'($urandom), on_active_line());
            send_request(ACT_COPY_HORIZ, 8'($urandom), on_active_line());
            if ($urandom_range(0, 3) == 0)
               send_request(ACT_COPY_VERT, 8'($urandom), on_active_line());
         end else if (kind < 68) begin
            repeat ($urandom_range(1, 6)) begin
               send_request($urandom_range(0, 1) ? ACT_DATA_RD : ACT_DATA_WR,
                            8'($urandom), 1'($urandom_range(0, 1)));
               send_ticks($urandom_range(0, 7));
            end
         end else if (kind < 78) begin
            send_request(ACT_CTRL_WR, 8'($urandom), on_active_line());
            send_mask_write();
         end else if (kind < 86) begin
            send_request(ACT_STATUS_RD, 8'($urandom), on_active_line());
            send_request($urandom_range(0, 1) ? ACT_SCROLL_WR : ACT_ADDR_WR,
                         8'($urandom), on_active_line());
         end else if (kind < 95) begin
            send_request(4'($urandom_range(ACT_TICK, ACT_RESERVED_HI)), 8'($urandom),
                         1'($urandom_range(0, 1)));
         end else begin
            send_ticks($urandom_range(1, 10));
         end
      end

      pause_requests();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (book.outstanding() != 0)
         book.report("responses never returned", 16'(book.outstanding()), '0);
      $display("run covered %0d requests and %0d responses, %0d VRAM accesses",
               items_sent, book.responses, book.accesses);
      $display("%0d reads under lockout, %0d delayed address loads, %0d vertical wraps",
               book.locked_reads, book.delayed_loads, book.y_flips);
      if (book.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
